// ----- design/wat_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types and constants for the weekly alarm table matcher.
// ----------------------------------------------------------------------------
package wat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 4;
    localparam int CMP_W       = CNT_W + SLOT_W;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DEL    = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_CANCEL = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [2:0] SUNDAY_BIT    = 3'd6;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic [6:0] days;
    } alarm_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        alarm_t           data;
    } tbl_wr_t;

endpackage : wat_pkg
`default_nettype wire

// ----- design/wat_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wat_table
// Alarm entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wat_table
    import wat_pkg::*;
(
    input  wire logic             aclk,
    input  wire tbl_wr_t          wr,
    input  wire logic [IDX_W-1:0] raddr,
    output alarm_t                rdata
);

    alarm_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule : wat_table
`default_nettype wire

// ----- design/weekly_alarm_table_matcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_alarm_table_matcher
// Alarm table with add, delete, update, read, cancel and time check.
// ----------------------------------------------------------------------------
// States per item: add, update, cancel, delete of the last entry and rejected
// items go from S_IDLE straight to S_DONE; read passes S_RDWAIT and a delete
// that moves the last entry passes S_MOVE. Check goes straight to S_DONE on an
// empty table, else S_SCAN reads entries in order to the first match or end.
// One item in flight; the next is taken once S_DONE loads the output register.
// Reset: table empty, not ringing, no active entry; entry storage not cleared.
// ----------------------------------------------------------------------------
module weekly_alarm_table_matcher
    import wat_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_operation,
    input  wire logic [3:0] s_slot,
    input  wire logic [4:0] s_set_hour,
    input  wire logic [5:0] s_set_minute,
    input  wire logic       s_set_enabled,
    input  wire logic [6:0] s_set_days,
    input  wire logic [5:0] s_now_hour,
    input  wire logic [5:0] s_now_minute,
    input  wire logic [2:0] s_now_day,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic [3:0]      m_slot_used,
    output logic            m_ringing,
    output logic            m_active_valid,
    output logic [3:0]      m_active_slot,
    output logic [4:0]      m_entry_hour,
    output logic [5:0]      m_entry_minute,
    output logic            m_entry_enabled,
    output logic [6:0]      m_entry_days,
    output logic [4:0]      m_entry_count
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_MOVE   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_used;
        alarm_t     entry;
    } result_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ring_reg, ring_next;
    logic             act_valid_reg, act_valid_next;
    logic [IDX_W-1:0] act_idx_reg, act_idx_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [3:0]       slot_reg, slot_next;
    logic [5:0]       hr_reg, hr_next;
    logic [5:0]       mn_reg, mn_next;
    logic [2:0]       bit_reg, bit_next;
    result_t          res_reg, res_next;

    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;
    logic             out_ring_reg, out_act_valid_reg;
    logic [3:0]       out_act_slot_reg;
    logic [4:0]       out_count_reg;

    tbl_wr_t          wr;
    logic [IDX_W-1:0] raddr;
    alarm_t           rdata;

    logic             out_free;
    logic             out_load;
    logic             slot_in_range;
    logic             slot_not_last;
    logic             entry_hit;
    alarm_t           in_rec;

    wat_table u_table (
        .aclk  (aclk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign in_rec = '{hour: s_set_hour, minute: s_set_minute,
                      enabled: s_set_enabled, days: s_set_days};

    assign slot_in_range = CMP_W'(s_slot) < CMP_W'(count_reg);
    assign slot_not_last = (CMP_W'(s_slot) + CMP_W'(1)) < CMP_W'(count_reg);

    assign entry_hit = rdata.enabled
                     && ({1'b0, rdata.hour} == hr_reg)
                     && (rdata.minute == mn_reg)
                     && ((rdata.days == 7'd0) || rdata.days[bit_reg]);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ring_next      = ring_reg;
        act_valid_next = act_valid_reg;
        act_idx_next   = act_idx_reg;
        scan_next      = scan_reg;
        slot_next      = slot_reg;
        hr_next        = hr_reg;
        mn_next        = mn_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        wr             = '0;
        raddr          = '0;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    slot_next  = s_slot;
                    hr_next    = (s_now_hour >= HOURS_PER_DAY) ?
                                 (s_now_hour - HOURS_PER_DAY) : s_now_hour;
                    mn_next    = s_now_minute;
                    bit_next   = (s_now_day == 3'd0) ? SUNDAY_BIT
                               : ((s_now_day == 3'd7) ? SUNDAY_BIT
                                                      : (s_now_day - 3'd1));
                    res_next   = '{status: ST_OK, slot_used: 4'd0, entry: '0};
                    state_next = S_DONE;
                    unique case (s_operation)
                        OP_ADD: begin
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr.en              = 1'b1;
                                wr.addr            = IDX_W'(count_reg);
                                wr.data            = in_rec;
                                res_next.slot_used = 4'(count_reg);
                                count_next         = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL: begin
                            if (!slot_in_range) begin
                                res_next.status = ST_RANGE;
                            end else if (slot_not_last) begin
                                raddr      = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_MOVE;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_UPDATE: begin
                            if (!slot_in_range) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                wr.en   = 1'b1;
                                wr.addr = IDX_W'(s_slot);
                                wr.data = in_rec;
                            end
                        end
                        OP_CHECK: begin
                            raddr     = '0;
                            scan_next = '0;
                            if (count_reg != '0) begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CANCEL: begin
                            if (ring_reg) begin
                                ring_next      = 1'b0;
                                act_valid_next = 1'b0;
                                act_idx_next   = '0;
                            end
                        end
                        OP_READ: begin
                            if (!slot_in_range) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                raddr      = IDX_W'(s_slot);
                                state_next = S_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                res_next.entry     = rdata;
                res_next.slot_used = slot_reg;
                state_next         = S_DONE;
            end
            S_MOVE: begin
                wr.en      = 1'b1;
                wr.addr    = IDX_W'(slot_reg);
                wr.data    = rdata;
                count_next = count_reg - CNT_W'(1);
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (entry_hit) begin
                    ring_next      = 1'b1;
                    act_valid_next = 1'b1;
                    act_idx_next   = scan_reg;
                    state_next     = S_DONE;
                end else if ((CNT_W'(scan_reg) + CNT_W'(1)) < count_reg) begin
                    scan_next = scan_reg + IDX_W'(1);
                    raddr     = scan_reg + IDX_W'(1);
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
        out_next = out_load ? res_reg : out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ring_reg      <= 1'b0;
            act_valid_reg <= 1'b0;
            act_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ring_reg      <= ring_next;
            act_valid_reg <= act_valid_next;
            act_idx_reg   <= act_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        slot_reg <= slot_next;
        hr_reg   <= hr_next;
        mn_reg   <= mn_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (out_load) begin
            out_ring_reg      <= ring_reg;
            out_act_valid_reg <= act_valid_reg;
            out_act_slot_reg  <= act_valid_reg ? 4'(act_idx_reg) : 4'd0;
            out_count_reg     <= 5'(count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_slot_used     = out_reg.slot_used;
    assign m_ringing       = out_ring_reg;
    assign m_active_valid  = out_act_valid_reg;
    assign m_active_slot   = out_act_slot_reg;
    assign m_entry_hour    = out_reg.entry.hour;
    assign m_entry_minute  = out_reg.entry.minute;
    assign m_entry_enabled = out_reg.entry.enabled;
    assign m_entry_days    = out_reg.entry.days;
    assign m_entry_count   = out_count_reg;

endmodule : weekly_alarm_table_matcher
`default_nettype wire
